// ===== src/swra_pkg.sv =====
// shared types and constants for the stack with running average unit
// operation and status codes, controller states, default sizes; no dependencies
`timescale 1ns / 1ps

package swra_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 32;
  // fraction bits of the fixed-point mean
  localparam int FRAC_BITS = 8;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PREP = 2'd1,
    S_DIV  = 2'd2,
    S_DONE = 2'd3
  } state_e;

endpackage

// ===== src/stack_with_running_average_unit.sv =====
// an accepted request passes S_PREP, S_DIV and S_DONE; the divider for the mean works on DIV_W =
//   VALUE_WIDTH + clog2(STACK_DEPTH) + 8 bits (46 at default sizes); S_DIV is skipped when the stack ends empty
// one request at a time: no new request is taken until its result is loaded; the restoring divider
//   for the mean yields one quotient bit per cycle; a stalled result waits at the end
// reset: asynchronous, active low; stack empty, zero sum, element storage left uncleared
// depends on swra_pkg
`timescale 1ns / 1ps

module stack_with_running_average_unit #(
  parameter int STACK_DEPTH = swra_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = swra_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  // request channel
  input  logic                                             in_valid_i,
  output logic                                             in_stall_o,
  input  logic [1:0]                                       operation_i,
  input  logic signed [VALUE_WIDTH-1:0]                    push_value_i,
  // result channel
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output logic [1:0]                                       status_o,
  output logic                                             is_empty_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]                 element_count_o,
  output logic                                             top_valid_o,
  output logic signed [VALUE_WIDTH-1:0]                    top_value_o,
  output logic signed [VALUE_WIDTH+swra_pkg::FRAC_BITS-1:0] mean_fixed_o
);
  import swra_pkg::*;

  // count holds 0..STACK_DEPTH, address holds 0..STACK_DEPTH-1
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // sum of STACK_DEPTH signed values can never overflow this width
  localparam int SUM_W  = VALUE_WIDTH + $clog2(STACK_DEPTH);
  // scaled dividend magnitude, one quotient bit per cycle
  localparam int DIV_W  = SUM_W + FRAC_BITS;
  localparam int MEAN_W = VALUE_WIDTH + FRAC_BITS;
  localparam int BIT_W  = $clog2(DIV_W);

  // controller
  state_e state_q, state_d;

  // stack bookkeeping
  logic [CNT_W-1:0]              fill_q, fill_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [VALUE_WIDTH-1:0] top_q;
  status_e                       status_q, status_d;
  logic                          pop_q;

  // element storage, registered read port
  logic signed [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_q;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;

  // serial divider: shreg_q carries dividend bits out at the top and quotient bits in
  logic [DIV_W-1:0]              shreg_q;
  logic [CNT_W-1:0]              rem_q;
  logic                          neg_q;
  logic [BIT_W-1:0]              bit_q;
  logic [SUM_W-1:0]              sum_mag;
  logic [CNT_W:0]                rem_sh;
  logic [CNT_W:0]                rem_sub;
  logic                          q_bit;

  // result register
  logic                          out_valid_q;
  status_e                       res_status_q;
  logic                          res_empty_q;
  logic [CNT_W-1:0]              res_count_q;
  logic                          res_top_valid_q;
  logic signed [VALUE_WIDTH-1:0] res_top_q;
  logic signed [MEAN_W-1:0]      res_mean_q;

  logic                          in_acc;
  logic                          res_free;
  logic                          res_load;

  // the result register can take a new result when empty or being drained
  assign res_free = !out_valid_q || !out_stall_i;

  // new top after a pop sits two below the old count
  assign rd_addr = AW'(fill_q - CNT_W'(2));

  // magnitude of the sum; the most negative sum still fits unsigned
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // one restoring step against the element count
  assign rem_sh  = {rem_q, shreg_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, fill_q};
  assign q_bit   = (rem_sh >= {1'b0, fill_q});

  // next state, handshake and stack update
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    in_acc     = 1'b0;
    res_load   = 1'b0;
    fill_d     = fill_q;
    sum_d      = sum_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          in_acc   = 1'b1;
          status_d = ST_OK;
          state_d  = S_PREP;
          unique case (operation_i)
            OP_PUSH: begin
              if (fill_q >= CNT_W'(STACK_DEPTH)) begin
                status_d = ST_PUSH_FULL;
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + 1'b1;
                sum_d  = sum_q + SUM_W'(push_value_i);
              end
            end
            OP_POP: begin
              if (fill_q == '0) begin
                status_d = ST_POP_EMPTY;
              end else begin
                fill_d = fill_q - 1'b1;
                sum_d  = sum_q - SUM_W'(top_q);
              end
            end
            // query, and the unused code, leave the stack alone
            default: ;
          endcase
        end
      end
      S_PREP: begin
        // an empty stack has a zero sum, so the mean is already zero
        state_d = (fill_q == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (bit_q == BIT_W'(DIV_W - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      sum_q       <= '0;
      status_q    <= ST_OK;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      status_q <= status_d;
      if (in_acc) begin
        pop_q <= (operation_i == OP_POP) && (fill_q != '0);
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // storage, written on push and read every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(fill_q)] <= push_value_i;
    end
    rd_q <= mem[rd_addr];
  end

  // top of stack and divider datapath
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      top_q <= push_value_i;
    end else if (state_q == S_PREP && pop_q) begin
      top_q <= rd_q;
    end
    if (state_q == S_PREP) begin
      shreg_q <= {sum_mag, FRAC_BITS'(0)};
      neg_q   <= sum_q[SUM_W-1];
      rem_q   <= '0;
      bit_q   <= '0;
    end else if (state_q == S_DIV) begin
      shreg_q <= {shreg_q[DIV_W-2:0], q_bit};
      rem_q   <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      bit_q   <= bit_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q    <= status_q;
      res_empty_q     <= (fill_q == '0);
      res_count_q     <= fill_q;
      res_top_valid_q <= (fill_q != '0);
      res_top_q       <= (fill_q != '0) ? top_q : '0;
      // truncation toward zero: divide the magnitude, then restore the sign
      res_mean_q      <= MEAN_W'(neg_q ? -shreg_q : shreg_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign is_empty_o      = res_empty_q;
  assign element_count_o = res_count_q;
  assign top_valid_o     = res_top_valid_q;
  assign top_value_o     = res_top_q;
  assign mean_fixed_o    = res_mean_q;

  // count never passes the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(STACK_DEPTH))
    else $error("fill level beyond stack depth");

  // a push into a stack with room grows it by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == OP_PUSH && fill_q < CNT_W'(STACK_DEPTH)
      |=> fill_q == $past(fill_q) + 1'b1)
    else $error("push did not grow the stack");

  // a pop on an empty stack leaves it empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == OP_POP && fill_q == '0 |=> fill_q == '0)
    else $error("pop on empty stack changed the count");

  // the partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < fill_q)
    else $error("divider remainder out of range");

  // an empty result carries no top and a zero mean
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> !top_valid_o && mean_fixed_o == '0)
    else $error("empty result with top or mean set");

endmodule
